>>> design/ehm_pkg.sv
package ehm_pkg;

  localparam int HASH_W      = 32;
  localparam int CHAR_W      = 8;
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);
  localparam int DIV_CW      = $clog2(HASH_W);

  localparam logic [HASH_W-1:0] TOP_NIBBLE_MASK = 32'hf000_0000;
  localparam int FOLD_SHIFT = 24;
  localparam int STEP_SHIFT = 4;

  typedef struct packed {
    logic              valid;
    logic [HASH_W-1:0] data;
  } push_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

  function automatic logic [HASH_W-1:0] mix_byte(input logic [HASH_W-1:0] h,
                                                 input logic [CHAR_W-1:0] b);
    logic [HASH_W-1:0] s;
    logic [HASH_W-1:0] top;
    s   = (h << STEP_SHIFT) + {{(HASH_W-CHAR_W){1'b0}}, b};
    top = s & TOP_NIBBLE_MASK;
    return s ^ (top >> FOLD_SHIFT) ^ top;
  endfunction

endpackage

>>> design/ehm_front.sv
module ehm_front
  import ehm_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [CHAR_W-1:0] char_code,
  input  logic              last_char,
  input  queue_status_t     qstat,
  output push_t             push
);

  logic [HASH_W-1:0] running_hash;
  logic [HASH_W-1:0] mixed;
  logic              accept;

  // a full queue holds off every byte, so a string end never pushes into a full queue
  assign in_stall = qstat.full;
  assign accept   = in_valid && !in_stall;
  assign mixed    = mix_byte(running_hash, char_code);

  assign push.valid = accept && last_char;
  assign push.data  = mixed;

  always_ff @(posedge clk) begin
    if (rst) begin
      running_hash <= '0;
    end else if (accept) begin
      running_hash <= last_char ? '0 : mixed;
    end
  end

endmodule

>>> design/ehm_queue.sv
module ehm_queue
  import ehm_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  push_t             push,
  input  logic              pop,
  output logic [HASH_W-1:0] head,
  output queue_status_t     qstat
);

  logic [HASH_W-1:0]   entries [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wr_ptr;
  logic [QUEUE_AW-1:0] rd_ptr;
  logic [QUEUE_CW-1:0] fill;

  assign head        = entries[rd_ptr];
  assign qstat.full  = (fill == QUEUE_CW'(QUEUE_DEPTH));
  assign qstat.empty = (fill == '0);

  always_ff @(posedge clk) begin
    if (push.valid) begin
      entries[wr_ptr] <= push.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push.valid) begin
        wr_ptr <= (wr_ptr == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push.valid && !pop) begin
        fill <= fill + 1'b1;
      end else if (pop && !push.valid) begin
        fill <= fill - 1'b1;
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    !(push.valid && qstat.full))
    else $error("push into full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    !(pop && qstat.empty))
    else $error("pop from empty queue");

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= QUEUE_CW'(QUEUE_DEPTH))
    else $error("queue fill beyond depth");

endmodule

>>> design/ehm_back.sv
module ehm_back
  import ehm_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic [HASH_W-1:0] hash_range,
  input  logic [HASH_W-1:0] head,
  input  queue_status_t     qstat,
  output logic              pop,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [HASH_W-1:0] hash_code
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_DIV  = 3'b010,
    S_WAIT = 3'b100
  } state_t;

  state_t            state;
  logic [HASH_W-1:0] rem;
  logic [HASH_W-1:0] dvd;
  logic [DIV_CW-1:0] count;
  logic [HASH_W:0]   rem_sh;
  logic [HASH_W:0]   rng_ext;
  logic              ge;
  logic [HASH_W-1:0] rem_next;
  logic              slot_free;

  assign pop       = (state == S_IDLE) && !qstat.empty;
  assign slot_free = !out_valid || !out_stall;

  // one restoring step per cycle
  assign rem_sh   = {rem, dvd[HASH_W-1]};
  assign rng_ext  = {1'b0, hash_range};
  assign ge       = (rem_sh >= rng_ext);
  assign rem_next = ge ? HASH_W'(rem_sh - rng_ext) : rem_sh[HASH_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (state == S_WAIT && slot_free) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (pop) begin
            count <= '0;
            // zero range means the raw hash goes out
            state <= (hash_range == '0) ? S_WAIT : S_DIV;
          end
        end
        S_DIV: begin
          count <= count + 1'b1;
          if (count == DIV_CW'(HASH_W - 1)) begin
            state <= S_WAIT;
          end
        end
        S_WAIT: begin
          if (slot_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        if (pop) begin
          rem <= (hash_range == '0) ? head : '0;
          dvd <= head;
        end
      end
      S_DIV: begin
        rem <= rem_next;
        dvd <= {dvd[HASH_W-2:0], 1'b0};
      end
      S_WAIT: begin
        if (slot_free) begin
          hash_code <= rem;
        end
      end
      default: ;
    endcase
  end

  a_count_steps: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV && count != DIV_CW'(HASH_W - 1)) |=>
      (state == S_DIV && count == $past(count) + 1'b1))
    else $error("divider step skipped");

  a_pop_only_idle: assert property (@(posedge clk) disable iff (rst)
    pop |=> (state != S_IDLE))
    else $error("popped request not taken up");

endmodule

>>> design/elf_string_hash_mod_core.sv
// pjw/elf string hash reduced modulo a bucket count
//
// input channel: one character byte per request (char_code) with last_char
// set on the final byte. in_valid/in_stall; a request is taken on a rising
// edge with in_valid high and in_stall low; one byte per unstalled cycle.
// output channel: one hash_code per string, out_valid/out_stall.
// configuration: hash_range_we/hash_range_wdata write the bucket count;
// the user must write it only while the block is idle; the block itself
// does not enforce this. a zero bucket count gives the raw hash.
// flow: the finished hash of a string enters a four-deep queue at the
// edge that takes its last byte; the back end pops it when idle, runs a
// restoring division (one quotient bit per cycle) unless the bucket count
// is zero, and then loads the output register. the back end takes a new
// hash only after it has loaded the last one into the output register;
// up to four finished hashes queue up.
// in_stall rises only when the queue is full.
// reset clears the running hash, the queue and out_valid, and sets the
// bucket count to 1. a stalled output holds its value; the divider then
// waits with the next result until the output register frees up.
module elf_string_hash_mod_core
  import ehm_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              hash_range_we,
  input  logic [HASH_W-1:0] hash_range_wdata,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [CHAR_W-1:0] char_code,
  input  logic              last_char,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [HASH_W-1:0] hash_code
);

  logic [HASH_W-1:0] hash_range;
  push_t             push;
  queue_status_t     qstat;
  logic              pop;
  logic [HASH_W-1:0] head;

  always_ff @(posedge clk) begin
    if (rst) begin
      hash_range <= HASH_W'(1);
    end else if (hash_range_we) begin
      hash_range <= hash_range_wdata;
    end
  end

  ehm_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .char_code (char_code),
    .last_char (last_char),
    .qstat     (qstat),
    .push      (push)
  );

  ehm_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .pop   (pop),
    .head  (head),
    .qstat (qstat)
  );

  ehm_back u_back (
    .clk        (clk),
    .rst        (rst),
    .hash_range (hash_range),
    .head       (head),
    .qstat      (qstat),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .hash_code  (hash_code)
  );

endmodule

>>> tb/elf_string_hash_mod_core_tb.sv
`timescale 1ns / 100ps

module elf_string_hash_mod_core_tb;
  import ehm_pkg::*;

  localparam int LIMIT_CYCLES = 1_000_000;
  // time for the back end to finish a string, with some margin
  localparam int SETTLE_CYCLES = 48;
  localparam int ITEMS_PER_PHASE = 530;
  localparam int ITEMS_PER_RANGE = 130;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              hash_range_we = 1'b0;
  logic [HASH_W-1:0] hash_range_wdata = '0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [CHAR_W-1:0] char_code = '0;
  logic              last_char = 1'b0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [HASH_W-1:0] hash_code;

  // predictor state
  logic [HASH_W-1:0] model_range = 32'd1;
  logic [HASH_W-1:0] model_hash = '0;
  logic [HASH_W-1:0] pending_hashes[$];

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int errors = 0;
  int cycles = 0;

  elf_string_hash_mod_core u_top (
    .clk              (clk),
    .rst              (rst),
    .hash_range_we    (hash_range_we),
    .hash_range_wdata (hash_range_wdata),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .char_code        (char_code),
    .last_char        (last_char),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .hash_code        (hash_code)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYCLES) begin
      $display("tb: failure");
      $finish;
    end
  end

  always @(negedge clk) begin
    out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
  end

  // step the running hash by one byte; fold the top nibble back in
  function automatic logic [HASH_W-1:0] pjw_step(input logic [HASH_W-1:0] h,
                                                 input logic [CHAR_W-1:0] b);
    logic [HASH_W-1:0] acc;
    logic [3:0]        nib;
    acc = {h[HASH_W-5:0], 4'b0000} + {24'd0, b};
    nib = acc[31:28];
    if (nib != 4'd0) begin
      acc[7:4]   = acc[7:4] ^ nib;
      acc[31:28] = 4'd0;
    end
    return acc;
  endfunction

  task automatic hash_char(input logic [CHAR_W-1:0] b, input logic fin);
    logic [HASH_W-1:0] bucket;
    model_hash = pjw_step(model_hash, b);
    if (fin) begin
      bucket = (model_range == '0) ? model_hash : model_hash % model_range;
      pending_hashes.push_back(bucket);
      model_hash = '0;
    end
  endtask

  always @(posedge clk) begin : check_results
    logic [HASH_W-1:0] want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_hashes.size() == 0) begin
        $error("hash_code: no result pending, actual %0h", hash_code);
        errors++;
      end else begin
        want = pending_hashes.pop_front();
        if (hash_code !== want) begin
          $error("hash_code mismatch: expected %0h, actual %0h", want, hash_code);
          errors++;
        end
      end
    end
  end

  // one request, held until the block takes it
  task automatic send_char(input logic [CHAR_W-1:0] b, input logic fin);
    @(negedge clk);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid  <= 1'b1;
    char_code <= b;
    last_char <= fin;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    hash_char(b, fin);
  endtask

  task automatic send_string(input logic [CHAR_W-1:0] chars[$]);
    foreach (chars[i]) send_char(chars[i], i == chars.size() - 1);
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_hashes.size() != 0) @(posedge clk);
  endtask

  task automatic write_range(input logic [HASH_W-1:0] value);
    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
    hash_range_we    <= 1'b1;
    hash_range_wdata <= value;
    @(negedge clk);
    hash_range_we <= 1'b0;
    model_range = value;
  endtask

  task automatic test_directed();
    logic [CHAR_W-1:0] s[$];
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    // bucket count of one after reset
    s = '{8'h41};
    send_string(s);
    s = '{8'h68, 8'h69};
    send_string(s);
    // zero bucket count gives the raw hash
    write_range(32'd0);
    s = '{8'hff};
    send_string(s);
    s = '{8'h00};
    send_string(s);
    // high bytes add unsigned
    s = '{8'h80};
    send_string(s);
    // zero byte inside a string does not end it
    s = '{8'h61, 8'h00, 8'h62};
    send_string(s);
    // enough bytes to set the top nibble and fold
    s = '{8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff};
    send_string(s);
    write_range(32'hffff_ffff);
    s = '{8'hf0, 8'h0f, 8'h55, 8'haa, 8'h01};
    send_string(s);
    write_range(32'd7);
    s = '{8'h7f};
    send_string(s);
    s = '{8'h01, 8'h02};
    send_string(s);
  endtask

  task automatic test_random(input int idle_in, input int stall_out);
    logic [CHAR_W-1:0] s[$];
    int                sent;
    int                since_cfg;
    int                len;
    int                pick;
    send_idle_pct  = idle_in;
    recv_stall_pct = stall_out;
    sent      = 0;
    since_cfg = 0;
    while (sent < ITEMS_PER_PHASE) begin
      if (since_cfg >= ITEMS_PER_RANGE) begin
        pick = $urandom_range(0, 6);
        case (pick)
          0: write_range(32'd1);
          1: write_range(32'd0);
          2: write_range(32'hffff_ffff);
          3: write_range(32'd2);
          4: write_range($urandom_range(1, 1000));
          5: write_range(32'h1000_0000 - $urandom_range(0, 15));
          default: write_range($urandom);
        endcase
        since_cfg = 0;
      end
      len = ($urandom_range(0, 99) < 85) ? $urandom_range(1, 12) : $urandom_range(13, 48);
      s = {};
      repeat (len) begin
        pick = $urandom_range(0, 19);
        if (pick == 0) s.push_back(8'h00);
        else if (pick == 1) s.push_back(8'hff);
        else s.push_back(CHAR_W'($urandom_range(0, 255)));
      end
      send_string(s);
      sent      += len;
      since_cfg += len;
      // now and then let the block run dry before the next string
      if ($urandom_range(0, 39) == 0) drain();
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_directed();
    test_random(8, 50);
    write_range($urandom_range(3, 255));
    test_random(50, 8);
    write_range($urandom);
    test_random(0, 0);
    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

>>> elf_string_hash_mod_core.f
design/ehm_pkg.sv
design/ehm_front.sv
design/ehm_queue.sv
design/ehm_back.sv
design/elf_string_hash_mod_core.sv
tb/elf_string_hash_mod_core_tb.sv
